// ===== src/slpg_pkg.sv =====
// Package with shared types, constants and the SOS duration table for the status LED generator.
package slpg_pkg;

    // Field and state widths.
    localparam int L_TIME_W     = 40;
    localparam int L_MODE_W     = 3;
    localparam int L_STEP_W     = 5;
    localparam int L_DUR_W      = 10;
    localparam int L_APB_ADDR_W = 3;
    localparam int L_APB_DATA_W = 32;

    // Remainder widths delivered by the residue pipelines.
    localparam int L_REM125_W = 7;
    localparam int L_REM625_W = 10;
    localparam int L_REM15_W  = 4;

    // Blink periods and heartbeat timing in milliseconds.
    localparam int L_PERIOD_CONN  = 250;
    localparam int L_PERIOD_AP    = 1000;
    localparam int L_PERIOD_DMX   = 500;
    localparam int L_PERIOD_STRIP = 120;
    localparam int L_PERIOD_OK    = 2500;
    localparam int L_OK_ON_MS     = 80;

    // Number of entries in the SOS duration table.
    localparam int L_SOS_TABLE_LEN = 18;

    // Register indexes on the configuration port.
    localparam logic L_REG_LED_ENABLE = 1'b0;
    localparam logic L_REG_POLARITY   = 1'b1;

    // Display modes.
    typedef enum logic [L_MODE_W-1:0] {
        MODE_BOOT          = 3'd0,
        MODE_CONNECTING    = 3'd1,
        MODE_AP            = 3'd2,
        MODE_DMX           = 3'd3,
        MODE_OK            = 3'd4,
        MODE_STRIP_FAULT   = 3'd5,
        MODE_GENERAL_FAULT = 3'd6,
        MODE_OFF           = 3'd7
    } t_mode;

    // Stage load enables of the item pipeline.
    typedef struct packed {
        logic ld0;
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld_out;
    } t_adv;

    // Duration of one SOS step; steps past the table length wrap into it.
    function automatic logic [L_DUR_W-1:0] slpg_sos_dur(input logic [L_STEP_W-1:0] step);
        logic [L_STEP_W-1:0] idx;
        logic [L_DUR_W-1:0]  dur;
        idx = (step >= L_STEP_W'(L_SOS_TABLE_LEN)) ? step - L_STEP_W'(L_SOS_TABLE_LEN) : step;
        case (idx)
            5'd5, 5'd6, 5'd8, 5'd10, 5'd11: dur = 10'd360;
            5'd17:                          dur = 10'd1000;
            default:                        dur = 10'd120;
        endcase
        return dur;
    endfunction

endpackage

// ===== src/slpg_cfg.sv =====
// APB-style register block holding the enable and polarity settings.
module slpg_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [slpg_pkg::L_APB_ADDR_W-1:0] paddr,
    input  logic [slpg_pkg::L_APB_DATA_W-1:0] pwdata,
    output logic [slpg_pkg::L_APB_DATA_W-1:0] prdata,
    output logic                              pready,
    output logic                              o_led_enable,
    output logic                              o_polarity
);
    import slpg_pkg::*;

    logic r_led_enable;
    logic r_polarity;
    logic wr_en;
    logic reg_idx;

    // A write completes in the access phase; the port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[2];

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_enable <= 1'b0;
            r_polarity   <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                L_REG_LED_ENABLE: r_led_enable <= pwdata[0];
                L_REG_POLARITY:   r_polarity   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            L_REG_LED_ENABLE: prdata[0] = r_led_enable;
            L_REG_POLARITY:   prdata[0] = r_polarity;
            default:          prdata = '0;
        endcase
    end

    assign o_led_enable = r_led_enable;
    assign o_polarity   = r_polarity;

endmodule

// ===== src/slpg_residue.sv =====
// Three-stage pipeline that reduces a wide time value modulo a small constant.
module slpg_residue #(
    parameter int P_MOD  = 125,
    parameter int P_IN_W = 37
) (
    input  logic                      i_clk,
    input  slpg_pkg::t_adv            i_adv,
    input  logic [P_IN_W-1:0]         i_value,
    output logic [$clog2(P_MOD)-1:0]  o_rem
);
    import slpg_pkg::*;

    localparam int CH_W   = 10;
    localparam int NCH    = (P_IN_W + CH_W - 1) / CH_W;
    localparam int PAD_W  = NCH * CH_W;
    localparam int REM_W  = $clog2(P_MOD);
    localparam int SUM_W  = $clog2(NCH * (2 ** CH_W) * P_MOD);
    localparam int K      = SUM_W + 1;
    localparam int RCP    = (2 ** K) / P_MOD;
    localparam int RCP_W  = $clog2(RCP + 1);
    localparam int PRD_W  = SUM_W + RCP_W;
    localparam int QW     = $clog2((2 ** SUM_W) / P_MOD + 1);

    // Residue of 2^(CH_W*k) for the chunk weights.
    function automatic int chunk_weight(input int k);
        int w;
        w = 1;
        for (int i = 0; i < k; i++) begin
            w = (w * (2 ** CH_W)) % P_MOD;
        end
        return w;
    endfunction

    logic [PAD_W-1:0] pad;
    logic [SUM_W-1:0] prod [NCH];
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0] r_sum;
    logic [PRD_W-1:0] prod_q;
    logic [QW-1:0]    r_q;
    logic [SUM_W-1:0] r_sum_b;
    logic [SUM_W-1:0] qm;
    logic [SUM_W-1:0] rem_w;
    logic [SUM_W-1:0] rem_c;
    logic [REM_W-1:0] r_rem;

    assign pad = PAD_W'(i_value);

    // Stage A: weighted sum of 10-bit chunks keeps the residue class.
    for (genvar k = 0; k < NCH; k++) begin : g_chunk
        localparam int W = chunk_weight(k);
        assign prod[k] = SUM_W'(pad[k*CH_W +: CH_W]) * SUM_W'(W);
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < NCH; k++) begin
            n_sum = n_sum + prod[k];
        end
    end

    // Stage B: quotient estimate by reciprocal multiplication, low by at most one.
    assign prod_q = PRD_W'(r_sum) * PRD_W'(RCP);

    // Stage C: remainder with a single correction step.
    assign qm    = SUM_W'(r_q) * SUM_W'(P_MOD);
    assign rem_w = r_sum_b - qm;
    assign rem_c = (rem_w >= SUM_W'(P_MOD)) ? rem_w - SUM_W'(P_MOD) : rem_w;

    // Stage registers advance with the item they belong to.
    always_ff @(posedge i_clk) begin
        if (i_adv.ld1) begin
            r_sum <= n_sum;
        end
        if (i_adv.ld2) begin
            r_q     <= QW'(prod_q >> K);
            r_sum_b <= r_sum;
        end
        if (i_adv.ld3) begin
            r_rem <= REM_W'(rem_c);
        end
    end

    assign o_rem = r_rem;

endmodule

// ===== src/slpg_pipe_ctrl.sv =====
// Valid tracking and stage load enables for the item pipeline and output register.
module slpg_pipe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output slpg_pkg::t_adv o_adv
);
    import slpg_pkg::*;

    logic [3:0] r_v;
    logic       r_out_valid;
    t_adv       adv;

    // A stage loads when it holds nothing or its content moves on in the same cycle.
    always_comb begin
        adv.ld_out = r_v[3] & (~r_out_valid | i_ready);
        adv.ld3    = r_v[2] & (~r_v[3] | adv.ld_out);
        adv.ld2    = r_v[1] & (~r_v[2] | adv.ld3);
        adv.ld1    = r_v[0] & (~r_v[1] | adv.ld2);
        o_ready    = ~r_v[0] | adv.ld1;
        adv.ld0    = i_valid & o_ready;
    end

    // Stage occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_v[0]      <= adv.ld0 | (r_v[0] & ~adv.ld1);
            r_v[1]      <= adv.ld1 | (r_v[1] & ~adv.ld2);
            r_v[2]      <= adv.ld2 | (r_v[2] & ~adv.ld3);
            r_v[3]      <= adv.ld3 | (r_v[3] & ~adv.ld_out);
            r_out_valid <= adv.ld_out | (r_out_valid & ~i_ready);
        end
    end

    assign o_valid = r_out_valid;
    assign o_adv   = adv;

endmodule

// ===== src/slpg_core.sv =====
// Mode, SOS sequencing and LED state update with the result register.
module slpg_core #(
    parameter int P_SOS_STEPS = 18
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  slpg_pkg::t_adv                      i_adv,
    input  logic                                i_func,
    input  logic [slpg_pkg::L_MODE_W-1:0]       i_mode,
    input  logic [slpg_pkg::L_TIME_W-1:0]       i_now,
    input  logic [slpg_pkg::L_REM125_W-1:0]     i_rem125,
    input  logic [slpg_pkg::L_REM625_W-1:0]     i_rem625,
    input  logic [slpg_pkg::L_REM15_W-1:0]      i_rem15,
    input  logic                                i_led_enable,
    input  logic                                i_polarity,
    output logic                                o_led_on,
    output logic                                o_pin_level,
    output logic                                o_pin_driven
);
    import slpg_pkg::*;

    localparam logic [L_STEP_W:0] L_STEPS = (L_STEP_W + 1)'(P_SOS_STEPS);

    t_mode                r_mode;
    t_mode                n_mode;
    logic [L_TIME_W-1:0]  r_phase;
    logic [L_TIME_W-1:0]  n_phase;
    logic [L_STEP_W-1:0]  r_step;
    logic [L_STEP_W-1:0]  n_step;
    logic                 r_led;
    logic                 n_led;
    logic                 r_led_on;
    logic                 r_pin_level;
    logic                 r_pin_driven;

    logic [L_STEP_W-1:0]  step_eff;
    logic [L_STEP_W:0]    step_inc;
    logic [L_STEP_W-1:0]  step_next;
    logic [L_TIME_W-1:0]  elapsed;
    logic                 step_done;

    logic [9:0]           r1000;
    logic [9:0]           r500;
    logic [9:0]           r250;
    logic                 b_conn;
    logic                 b_ap;
    logic                 b_dmx;
    logic                 b_ok;
    logic                 b_strip;

    // Blink phases rebuilt from the residues and the low time bits.
    always_comb begin
        r1000   = {i_rem125, i_now[2:0]};
        r500    = (r1000 >= 10'(L_PERIOD_DMX)) ? r1000 - 10'(L_PERIOD_DMX) : r1000;
        r250    = (r500 >= 10'(L_PERIOD_CONN)) ? r500 - 10'(L_PERIOD_CONN) : r500;
        b_ap    = r1000 < 10'(L_PERIOD_AP / 2);
        b_dmx   = r500 < 10'(L_PERIOD_DMX / 2);
        b_conn  = r250 < 10'(L_PERIOD_CONN / 2);
        b_ok    = {i_rem625, i_now[1:0]} < 12'(L_OK_ON_MS);
        b_strip = {i_rem15, i_now[2:0]} < 7'(L_PERIOD_STRIP / 2);
    end

    // SOS step bookkeeping: a stale step restarts at zero, the last step wraps.
    always_comb begin
        step_eff  = ({1'b0, r_step} >= L_STEPS) ? '0 : r_step;
        step_inc  = {1'b0, step_eff} + 1'b1;
        step_next = (step_inc >= L_STEPS) ? '0 : step_inc[L_STEP_W-1:0];
        elapsed   = i_now - r_phase;
        step_done = elapsed >= L_TIME_W'(slpg_sos_dur(step_eff));
    end

    // Next state for one item.
    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        n_step  = r_step;
        n_led   = r_led;
        if (i_func) begin
            if (t_mode'(i_mode) != r_mode) begin
                n_mode  = t_mode'(i_mode);
                n_phase = i_now;
                n_step  = '0;
            end
        end else if (i_led_enable) begin
            case (r_mode)
                MODE_BOOT:        n_led = 1'b1;
                MODE_CONNECTING:  n_led = b_conn;
                MODE_AP:          n_led = b_ap;
                MODE_DMX:         n_led = b_dmx;
                MODE_OK:          n_led = b_ok;
                MODE_STRIP_FAULT: n_led = b_strip;
                MODE_GENERAL_FAULT: begin
                    n_led = ~step_eff[0];
                    if (step_done) begin
                        n_phase = i_now;
                        n_step  = step_next;
                    end else begin
                        n_step  = step_eff;
                    end
                end
                default:          n_led = 1'b0;
            endcase
        end
    end

    // State registers update when the item reaches the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BOOT;
            r_phase <= '0;
            r_step  <= '0;
            r_led   <= 1'b0;
        end else if (i_adv.ld_out) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_step  <= n_step;
            r_led   <= n_led;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_adv.ld_out) begin
            r_led_on     <= n_led;
            r_pin_level  <= i_polarity ? n_led : ~n_led;
            r_pin_driven <= i_led_enable;
        end
    end

    assign o_led_on     = r_led_on;
    assign o_pin_level  = r_pin_level;
    assign o_pin_driven = r_pin_driven;

endmodule

// ===== src/status_led_pattern_generator_top.sv =====
// Each item passes through the input register, three residue stages and the result register.
// Throughput: one item per cycle; the pipeline and result register advance whenever
// the downstream side takes a transfer or a stage ahead is empty.
// Reset (i_rst_n low, synchronous) empties the pipeline, sets boot mode with zero phase,
// SOS step and LED state, clears the enable register and selects high-for-on polarity.
// Top level of the status LED pattern generator.
module status_led_pattern_generator_top #(
    parameter int P_SOS_STEPS = 18
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_func,
    input  logic [slpg_pkg::L_MODE_W-1:0]     i_new_mode,
    input  logic [slpg_pkg::L_TIME_W-1:0]     i_now_ms,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_led_on,
    output logic                              o_pin_level,
    output logic                              o_pin_driven,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [slpg_pkg::L_APB_ADDR_W-1:0] paddr,
    input  logic [slpg_pkg::L_APB_DATA_W-1:0] pwdata,
    output logic [slpg_pkg::L_APB_DATA_W-1:0] prdata,
    output logic                              pready
);
    import slpg_pkg::*;

    t_adv                adv;
    logic                led_enable;
    logic                polarity;
    logic                r_func [4];
    logic [L_MODE_W-1:0] r_mode [4];
    logic [L_TIME_W-1:0] r_now  [4];
    logic [L_REM125_W-1:0] rem125;
    logic [L_REM625_W-1:0] rem625;
    logic [L_REM15_W-1:0]  rem15;

    // Configuration registers.
    slpg_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_led_enable (led_enable),
        .o_polarity   (polarity)
    );

    // Handshake and stage enables.
    slpg_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_adv   (adv)
    );

    // Item fields travel alongside the residue pipelines.
    always_ff @(posedge i_clk) begin
        if (adv.ld0) begin
            r_func[0] <= i_func;
            r_mode[0] <= i_new_mode;
            r_now[0]  <= i_now_ms;
        end
        if (adv.ld1) begin
            r_func[1] <= r_func[0];
            r_mode[1] <= r_mode[0];
            r_now[1]  <= r_now[0];
        end
        if (adv.ld2) begin
            r_func[2] <= r_func[1];
            r_mode[2] <= r_mode[1];
            r_now[2]  <= r_now[1];
        end
        if (adv.ld3) begin
            r_func[3] <= r_func[2];
            r_mode[3] <= r_mode[2];
            r_now[3]  <= r_now[2];
        end
    end

    // (now / 8) mod 125 gives now mod 1000, 500 and 250.
    slpg_residue #(.P_MOD(125), .P_IN_W(L_TIME_W - 3)) u_res125 (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_value (r_now[0][L_TIME_W-1:3]),
        .o_rem   (rem125)
    );

    // (now / 4) mod 625 gives now mod 2500.
    slpg_residue #(.P_MOD(625), .P_IN_W(L_TIME_W - 2)) u_res625 (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_value (r_now[0][L_TIME_W-1:2]),
        .o_rem   (rem625)
    );

    // (now / 8) mod 15 gives now mod 120.
    slpg_residue #(.P_MOD(15), .P_IN_W(L_TIME_W - 3)) u_res15 (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_value (r_now[0][L_TIME_W-1:3]),
        .o_rem   (rem15)
    );

    // State update and result register.
    slpg_core #(.P_SOS_STEPS(P_SOS_STEPS)) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_func       (r_func[3]),
        .i_mode       (r_mode[3]),
        .i_now        (r_now[3]),
        .i_rem125     (rem125),
        .i_rem625     (rem625),
        .i_rem15      (rem15),
        .i_led_enable (led_enable),
        .i_polarity   (polarity),
        .o_led_on     (o_led_on),
        .o_pin_level  (o_pin_level),
        .o_pin_driven (o_pin_driven)
    );

endmodule
